>>> sv/perceptron_branch_predictor_macros.svh
// Assertion macros for the perceptron branch predictor checker.
// Used by pcp_checker.sv; needs nothing else.
`ifndef PERCEPTRON_BRANCH_PREDICTOR_MACROS_SVH
`define PERCEPTRON_BRANCH_PREDICTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define PCP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcp check failed");

// Next-cycle implication, disabled while reset is high
`define PCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcp check failed");

`endif

>>> sv/pcp_pkg.sv
// Shared types and constants for the perceptron branch predictor.
// No dependencies.
`timescale 1ns / 1ps

package pcp_pkg;

   // branch address width and result sum width are fixed by the interface
   localparam int ADDRESS_BITS   = 64;
   localparam int SUM_OUT_BITS   = 14;

   // training threshold register
   localparam int THRESHOLD_BITS = 8;
   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 8'd44;

   // sequencer states, one-hot
   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_SUM    = 6'b000100,
      ST_DECIDE = 6'b001000,
      ST_TRAIN  = 6'b010000,
      ST_RESP   = 6'b100000
   } state_type;

endpackage

>>> sv/pcp_wmem.sv
// Weight memory: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pcp_wmem #(
   parameter int DATA_BITS = 9,
   parameter int DEPTH = 4352,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data
);

   logic [DATA_BITS-1:0] weight_mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         weight_mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= weight_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/pcp_core.sv
// Sequencer and datapath: clearing pass, weighted sum, training read-modify-write,
// global history and the result register. Depends on pcp_pkg and an external pcp_wmem.
`timescale 1ns / 1ps

module pcp_core import pcp_pkg::*; #(
   parameter int INDEX_BITS = 8,
   parameter int HISTORY_LEN = 16,
   parameter int WEIGHT_BITS = 9,
   localparam int ROW_LEN = HISTORY_LEN + 1,
   localparam int DEPTH = (1 << INDEX_BITS) * ROW_LEN,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ADDRESS_BITS-1:0]           req_branch_address,
   input  logic                              req_taken,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_predicted_taken,
   output logic signed [SUM_OUT_BITS-1:0]    rsp_weighted_sum,
   output logic                              rsp_trained,
   input  logic [THRESHOLD_BITS-1:0]         threshold,
   output logic                              mem_rd_en,
   output logic [ADDR_BITS-1:0]              mem_rd_addr,
   input  logic [WEIGHT_BITS-1:0]            mem_rd_data,
   output logic                              mem_wr_en,
   output logic [ADDR_BITS-1:0]              mem_wr_addr,
   output logic [WEIGHT_BITS-1:0]            mem_wr_data
);

   localparam int CNT_BITS   = $clog2(ROW_LEN + 1);
   localparam int SUM_BITS   = WEIGHT_BITS + $clog2(ROW_LEN) + 1;
   localparam int EXT_BITS   = (SUM_BITS > SUM_OUT_BITS) ? SUM_BITS : SUM_OUT_BITS;
   localparam int MAG_BITS   = (SUM_BITS > THRESHOLD_BITS) ? SUM_BITS : THRESHOLD_BITS;
   localparam int BND_BITS   =
      ((WEIGHT_BITS > THRESHOLD_BITS) ? WEIGHT_BITS : THRESHOLD_BITS) + 1;
   localparam int WEIGHT_MAX = (1 << (WEIGHT_BITS - 1)) - 1;
   localparam logic signed [SUM_BITS-1:0]  SUM_ZERO = '0;
   localparam logic signed [WEIGHT_BITS:0] STEP_ONE = 1;

   // control registers
   state_type                  state_ff, state_in;
   logic [ADDR_BITS-1:0]       clr_ff, clr_in;
   logic [CNT_BITS-1:0]        cnt_ff, cnt_in;
   logic                       dv_ff, dv_in;
   logic [HISTORY_LEN-1:0]     hist_ff, hist_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [ADDR_BITS-1:0]       base_ff, base_in;
   logic [ADDR_BITS-1:0]       wa_ff, wa_in;
   logic                       taken_ff, taken_in;
   logic [ROW_LEN-1:0]         sign_ff, sign_in;
   logic signed [SUM_BITS-1:0] acc_ff, acc_in;
   logic                       pred_ff, pred_in;
   logic                       train_ff, train_in;
   logic signed [SUM_OUT_BITS-1:0] sum_ff, sum_in;
   logic                       rsp_pred_ff, rsp_pred_in;
   logic signed [SUM_OUT_BITS-1:0] rsp_sum_ff, rsp_sum_in;
   logic                       rsp_train_ff, rsp_train_in;

   // datapath nets
   logic [ADDR_BITS-1:0]          rd_addr;
   logic                          issue;
   logic                          last;
   logic signed [WEIGHT_BITS-1:0] rd_w;
   logic signed [SUM_BITS-1:0]    w_ext;
   logic signed [SUM_BITS-1:0]    term;
   logic signed [WEIGHT_BITS:0]   w_step;
   logic signed [WEIGHT_BITS:0]   w_clamp;
   logic [BND_BITS-1:0]           theta_z;
   logic [BND_BITS-1:0]           bound_u;
   logic signed [WEIGHT_BITS:0]   bound_w;
   logic                          pred_now;
   logic signed [SUM_BITS-1:0]    mag_s;
   logic                          mag_lt;
   logic signed [EXT_BITS-1:0]    sum_ext;

   // row walk: one weight address per cycle, data in the next cycle
   assign rd_addr = base_ff + ADDR_BITS'(cnt_ff);
   assign issue   = ((state_ff == ST_SUM) || (state_ff == ST_TRAIN)) &&
                    (cnt_ff != CNT_BITS'(ROW_LEN));
   assign last    = dv_ff && (cnt_ff == CNT_BITS'(ROW_LEN));

   // sum term: weight added for a set sign bit, subtracted otherwise
   assign rd_w  = $signed(mem_rd_data);
   assign w_ext = SUM_BITS'(rd_w);
   assign term  = sign_ff[0] ? w_ext : -w_ext;

   // clamp bound is the smaller of theta and the largest storable weight
   assign theta_z = BND_BITS'(threshold);
   assign bound_u = (theta_z > BND_BITS'(WEIGHT_MAX)) ? BND_BITS'(WEIGHT_MAX) : theta_z;
   assign bound_w = $signed((WEIGHT_BITS + 1)'(bound_u));

   // training step: +1 when sign bit agrees with the outcome, else -1, then clamp
   assign w_step  = (WEIGHT_BITS + 1)'(rd_w) + ((sign_ff[0] == taken_ff) ? STEP_ONE
                                                                       : -STEP_ONE);
   assign w_clamp = (w_step > bound_w)  ? bound_w :
                    (w_step < -bound_w) ? -bound_w : w_step;

   // prediction and training decision on the full-precision sum
   assign pred_now = acc_ff > SUM_ZERO;
   assign mag_s    = (acc_ff < SUM_ZERO) ? -acc_ff : acc_ff;
   assign mag_lt   = MAG_BITS'($unsigned(mag_s)) < MAG_BITS'(threshold);
   assign sum_ext  = EXT_BITS'(acc_ff);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cnt_in       = cnt_ff;
      dv_in        = 1'b0;
      hist_in      = hist_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      base_in      = base_ff;
      wa_in        = wa_ff;
      taken_in     = taken_ff;
      sign_in      = sign_ff;
      acc_in       = acc_ff;
      pred_in      = pred_ff;
      train_in     = train_ff;
      sum_in       = sum_ff;
      rsp_pred_in  = rsp_pred_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_train_in = rsp_train_ff;
      req_ready    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = wa_ff;
      mem_wr_data  = w_clamp[WEIGHT_BITS-1:0];

      case (state_ff)
         ST_CLEAR: begin
            // zero the weight table, one entry per cycle
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
            if (clr_ff == ADDR_BITS'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               base_in  = ADDR_BITS'(req_branch_address[INDEX_BITS+1:2] * ROW_LEN);
               taken_in = req_taken;
               sign_in  = {hist_ff, 1'b1};
               hist_in  = HISTORY_LEN'({hist_ff, req_taken});
               acc_in   = SUM_ZERO;
               cnt_in   = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            dv_in = issue;
            wa_in = rd_addr;
            if (issue) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (dv_ff) begin
               acc_in  = acc_ff + term;
               sign_in = {sign_ff[0], sign_ff[ROW_LEN-1:1]};
            end
            if (last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            pred_in  = pred_now;
            train_in = (pred_now != taken_ff) || mag_lt;
            sum_in   = sum_ext[SUM_OUT_BITS-1:0];
            cnt_in   = '0;
            state_in = ((pred_now != taken_ff) || mag_lt) ? ST_TRAIN : ST_RESP;
         end
         ST_TRAIN: begin
            // read entry i while writing back entry i-1
            dv_in = issue;
            wa_in = rd_addr;
            if (issue) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (dv_ff) begin
               mem_wr_en = 1'b1;
               sign_in   = {sign_ff[0], sign_ff[ROW_LEN-1:1]};
            end
            if (last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pred_in  = pred_ff;
               rsp_sum_in   = sum_ff;
               rsp_train_in = train_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         dv_ff        <= 1'b0;
         hist_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         dv_ff        <= dv_in;
         hist_ff      <= hist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      wa_ff        <= wa_in;
      taken_ff     <= taken_in;
      sign_ff      <= sign_in;
      acc_ff       <= acc_in;
      pred_ff      <= pred_in;
      train_ff     <= train_in;
      sum_ff       <= sum_in;
      rsp_pred_ff  <= rsp_pred_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_train_ff <= rsp_train_in;
   end

   assign mem_rd_en           = issue;
   assign mem_rd_addr         = rd_addr;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_predicted_taken = rsp_pred_ff;
   assign rsp_weighted_sum    = rsp_sum_ff;
   assign rsp_trained         = rsp_train_ff;

endmodule

>>> sv/perceptron_branch_predictor.sv
// Perceptron branch predictor. Each transaction is one resolved branch; the block
// trains the row if needed and then returns the prediction and sum from the weights
// before training. All weights sit in one single-read-port memory, read one per cycle,
// and a branch is accepted only once the previous one has moved its result to the
// output register; a trained branch reads its row once for the sum and once more for
// the write-back. After reset a clearing pass zeroes all 2^INDEX_BITS*(HISTORY_LEN+1)
// entries (4352 at the defaults) with req_ready low; threshold writes are taken throughout.
// Depends on pcp_pkg, pcp_core and pcp_wmem.
`timescale 1ns / 1ps

module perceptron_branch_predictor import pcp_pkg::*; #(
   parameter int INDEX_BITS = 8,
   parameter int HISTORY_LEN = 16,
   parameter int WEIGHT_BITS = 9
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [ADDRESS_BITS-1:0]        req_branch_address,
   input  logic                           req_taken,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_predicted_taken,
   output logic signed [SUM_OUT_BITS-1:0] rsp_weighted_sum,
   output logic                           rsp_trained,
   input  logic                           csr_write_enable,
   input  logic [THRESHOLD_BITS-1:0]      csr_write_data
);

   localparam int ROW_LEN   = HISTORY_LEN + 1;
   localparam int DEPTH     = (1 << INDEX_BITS) * ROW_LEN;
   localparam int ADDR_BITS = $clog2(DEPTH);

   logic [THRESHOLD_BITS-1:0] threshold_ff, threshold_in;
   logic                      mem_rd_en;
   logic [ADDR_BITS-1:0]      mem_rd_addr;
   logic [WEIGHT_BITS-1:0]    mem_rd_data;
   logic                      mem_wr_en;
   logic [ADDR_BITS-1:0]      mem_wr_addr;
   logic [WEIGHT_BITS-1:0]    mem_wr_data;

   // training threshold register
   assign threshold_in = csr_write_enable ? csr_write_data : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   pcp_core #(
      .INDEX_BITS (INDEX_BITS),
      .HISTORY_LEN(HISTORY_LEN),
      .WEIGHT_BITS(WEIGHT_BITS)
   ) u_core (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_branch_address (req_branch_address),
      .req_taken          (req_taken),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_predicted_taken(rsp_predicted_taken),
      .rsp_weighted_sum   (rsp_weighted_sum),
      .rsp_trained        (rsp_trained),
      .threshold          (threshold_ff),
      .mem_rd_en          (mem_rd_en),
      .mem_rd_addr        (mem_rd_addr),
      .mem_rd_data        (mem_rd_data),
      .mem_wr_en          (mem_wr_en),
      .mem_wr_addr        (mem_wr_addr),
      .mem_wr_data        (mem_wr_data)
   );

   pcp_wmem #(
      .DATA_BITS(WEIGHT_BITS),
      .DEPTH    (DEPTH)
   ) u_wmem (
      .clock  (clock),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data)
   );

endmodule

>>> sv/pcp_checker.sv
// Port-level checks for the perceptron branch predictor, bound to the top level.
// Depends on pcp_pkg and perceptron_branch_predictor_macros.svh.
`timescale 1ns / 1ps
`include "perceptron_branch_predictor_macros.svh"

module pcp_checker import pcp_pkg::*; (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_predicted_taken,
   input logic signed [SUM_OUT_BITS-1:0] rsp_weighted_sum,
   input logic                           rsp_trained
);

   // table clearing keeps the input closed right after reset
   `PCP_ASSERT_IMPL(a_clear_after_reset, clock, reset, $past(reset), !req_ready)

   // one branch at a time: busy in the cycle after a transaction is taken
   `PCP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // a result never appears the cycle after acceptance
   `PCP_ASSERT_NEXT(a_no_early_result, clock, reset,
                    req_valid && req_ready && !rsp_valid, !rsp_valid)

   // a stalled result holds
   `PCP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_predicted_taken) &&
                    $stable(rsp_weighted_sum) && $stable(rsp_trained))

endmodule

bind perceptron_branch_predictor pcp_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_predicted_taken(rsp_predicted_taken),
   .rsp_weighted_sum   (rsp_weighted_sum),
   .rsp_trained        (rsp_trained)
);

>>> verif/testbench.sv
// Self-checking testbench for perceptron_branch_predictor: directed and random branch traffic,
// with outputs checked against a cycle-free perceptron predictor kept in step with the block.
// Depends on pcp_pkg and the perceptron_branch_predictor RTL.
`timescale 1ns / 1ps

module testbench import pcp_pkg::*;;

   localparam int INDEX_BITS    = 8;
   localparam int HISTORY_LEN   = 16;
   localparam int WEIGHT_BITS   = 9;
   localparam int ROWS          = 1 << INDEX_BITS;
   localparam int WEIGHT_MAX    = (1 << (WEIGHT_BITS - 1)) - 1;
   localparam int SETTLE_CYCLES = 2 * (HISTORY_LEN + 1) + 10;
   localparam int HOLD_CYCLES   = 300;
   localparam int LIMIT_CYCLES  = 300000;
   localparam int HOT_BRANCHES  = 6;
   localparam int MAX_REPORTS   = 10;

   localparam logic [ADDRESS_BITS-1:0] ROW_FIRST_ADDRESS = 64'h0000_0000_0000_0000;
   localparam logic [ADDRESS_BITS-1:0] ROW_LAST_ADDRESS  = 64'h0000_0000_0000_03FC;
   localparam logic [ADDRESS_BITS-1:0] CLAMP_ADDRESS     = 64'h0000_0000_0000_0014;

   // outcome patterns of the hot branches in random traffic
   typedef enum int {
      ALWAYS_TAKEN,
      LOOP_EXIT,
      FOLLOW_GLOBAL,
      ALTERNATE
   } branch_habit_type;

   typedef struct packed {
      logic                           predicted_taken;
      logic signed [SUM_OUT_BITS-1:0] weighted_sum;
      logic                           trained;
   } branch_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [ADDRESS_BITS-1:0]        req_branch_address = '0;
   logic                           req_taken = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic                           rsp_predicted_taken;
   logic signed [SUM_OUT_BITS-1:0] rsp_weighted_sum;
   logic                           rsp_trained;
   logic                           csr_write_enable = 1'b0;
   logic [THRESHOLD_BITS-1:0]      csr_write_data = '0;

   // shadow state of the predictor
   int                     weights [ROWS][HISTORY_LEN+1];
   logic [HISTORY_LEN-1:0] ghist = '0;
   int                     theta = THRESHOLD_RESET;
   branch_result_type      pending_results [$];

   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   perceptron_branch_predictor #(
      .INDEX_BITS (INDEX_BITS),
      .HISTORY_LEN(HISTORY_LEN),
      .WEIGHT_BITS(WEIGHT_BITS)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_branch_address (req_branch_address),
      .req_taken          (req_taken),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_predicted_taken(rsp_predicted_taken),
      .rsp_weighted_sum   (rsp_weighted_sum),
      .rsp_trained        (rsp_trained),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold on request
   always @(posedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   function automatic int limit_weight(input int w, input int bound);
      if (w > bound)
         return bound;
      if (w < -bound)
         return -bound;
      return w;
   endfunction

   // perceptron lookup and training for one resolved branch; queues the result
   task automatic predict_branch(input logic [ADDRESS_BITS-1:0] address, input logic outcome);
      int                row;
      int                y;
      int                magnitude;
      int                bound;
      int                i;
      logic              predicted;
      logic              train;
      branch_result_type r;
      row = address[INDEX_BITS+1:2];
      y = weights[row][0];
      for (i = 0; i < HISTORY_LEN; i++)
         y += ghist[i] ? weights[row][i+1] : -weights[row][i+1];
      predicted = (y > 0);
      magnitude = (y < 0) ? -y : y;
      train = (predicted != outcome) || (magnitude < theta);
      if (train) begin
         bound = (theta > WEIGHT_MAX) ? WEIGHT_MAX : theta;
         weights[row][0] = limit_weight(weights[row][0] + (outcome ? 1 : -1), bound);
         for (i = 0; i < HISTORY_LEN; i++)
            weights[row][i+1] = limit_weight(weights[row][i+1] + ((ghist[i] == outcome) ? 1 : -1),
                                             bound);
      end
      ghist = {ghist[HISTORY_LEN-2:0], outcome};
      r.predicted_taken = predicted;
      r.weighted_sum = y[SUM_OUT_BITS-1:0];
      r.trained = train;
      pending_results.push_back(r);
   endtask

   task automatic log_mismatch(input string what, input longint want, input longint got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("MISMATCH %s: expected %0d, got %0d (cycle %0d)", what, want, got, cycle_count);
   endtask

   // compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      branch_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            log_mismatch("result with no branch pending", 0, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_predicted_taken !== want.predicted_taken)
               log_mismatch("predicted_taken", want.predicted_taken, rsp_predicted_taken);
            if (rsp_weighted_sum !== want.weighted_sum)
               log_mismatch("weighted_sum", want.weighted_sum, rsp_weighted_sum);
            if (rsp_trained !== want.trained)
               log_mismatch("trained", want.trained, rsp_trained);
         end
      end
   end

   // one branch transaction; valid stays high after acceptance so a back-to-back
   // call keeps it asserted, wait_quiet drops it
   task automatic send_branch(input logic [ADDRESS_BITS-1:0] address, input logic outcome);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_branch_address <= address;
      req_taken <= outcome;
      do @(posedge clock); while (!req_ready);
      predict_branch(address, outcome);
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THRESHOLD_BITS-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      theta = value;
   endtask

   task automatic set_idling(input int send_pct, input int rsp_pct);
      send_idle_pct = send_pct;
      rsp_idle_pct <= rsp_pct;
   endtask

   // address extremes on a freshly cleared table, reset threshold
   task automatic test_address_extremes();
      set_idling(24, 58);
      send_branch(ROW_FIRST_ADDRESS, 1'b1);
      send_branch('1, 1'b0);
      send_branch(64'h5555_5555_5555_5555, 1'b1);
      send_branch(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      send_branch(ROW_FIRST_ADDRESS, 1'b1);
      send_branch(ROW_LAST_ADDRESS, 1'b1);
   endtask

   // zero threshold: weights pinned at zero, training only on a misprediction
   task automatic test_threshold_zero();
      wait_quiet();
      write_threshold('0);
      send_branch(ROW_FIRST_ADDRESS, 1'b1);
      send_branch(ROW_FIRST_ADDRESS, 1'b0);
      send_branch(ROW_LAST_ADDRESS, 1'b0);
      send_branch(ROW_LAST_ADDRESS, 1'b1);
   endtask

   // threshold one: the row saturates fast and training stops, then turns around
   task automatic test_weight_clamp();
      int n;
      wait_quiet();
      write_threshold(8'd1);
      for (n = 0; n < 8; n++)
         send_branch(CLAMP_ADDRESS, 1'b1);
      send_branch(CLAMP_ADDRESS, 1'b0);
      send_branch(CLAMP_ADDRESS, 1'b0);
   endtask

   // largest threshold, equal to the largest weight
   task automatic test_threshold_max();
      int n;
      wait_quiet();
      write_threshold('1);
      for (n = 0; n < 5; n++)
         send_branch(ROW_LAST_ADDRESS, n[0]);
   endtask

   // mostly a few hot branches with learnable habits, the rest random branches
   task automatic test_random_traffic(input int count, input logic [THRESHOLD_BITS-1:0] threshold,
                                      input int send_pct, input int rsp_pct);
      int                      hot_row [HOT_BRANCHES];
      int                      trip [HOT_BRANCHES];
      int                      visits [HOT_BRANCHES];
      logic                    own_last [HOT_BRANCHES];
      branch_habit_type        habit;
      logic [ADDRESS_BITS-1:0] address;
      logic                    outcome;
      int                      pick;
      int                      i;
      int                      n;
      wait_quiet();
      write_threshold(threshold);
      set_idling(send_pct, rsp_pct);
      for (i = 0; i < HOT_BRANCHES; i++) begin
         hot_row[i] = $urandom_range(ROWS - 1);
         trip[i] = $urandom_range(7, 3);
         visits[i] = 0;
         own_last[i] = 1'b0;
      end
      for (n = 0; n < count; n++) begin
         address = {$urandom, $urandom};
         if ($urandom_range(99) < 25) begin
            outcome = 1'($urandom_range(1));
         end else begin
            pick = $urandom_range(HOT_BRANCHES - 1);
            address[INDEX_BITS+1:2] = INDEX_BITS'(hot_row[pick]);
            habit = branch_habit_type'(pick % 4);
            case (habit)
               ALWAYS_TAKEN: outcome = 1'b1;
               LOOP_EXIT: begin
                  visits[pick]++;
                  outcome = (visits[pick] % trip[pick]) != 0;
               end
               FOLLOW_GLOBAL: outcome = ghist[0];
               default: outcome = ~own_last[pick];
            endcase
            // occasional noise on a habit
            if ($urandom_range(99) < 8)
               outcome = ~outcome;
            own_last[pick] = outcome;
         end
         send_branch(address, outcome);
      end
   endtask

   // long result stall while branches keep coming, so the input backs up
   task automatic test_output_backpressure();
      int n;
      wait_quiet();
      set_idling(0, 0);
      hold_requests <= hold_requests + 1;
      for (n = 0; n < 40; n++)
         send_branch({$urandom, $urandom}, 1'($urandom_range(1)));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_address_extremes();
      test_threshold_zero();
      test_weight_clamp();
      test_threshold_max();
      test_random_traffic(200, 8'd6, 24, 58);
      test_random_traffic(200, THRESHOLD_RESET, 58, 24);
      test_random_traffic(200, 8'($urandom_range(16, 1)), 0, 0);
      test_output_backpressure();
      wait_quiet();
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
